// ===== rtl/chte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and constants of the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int BUCKETS_DEF = 32;
  localparam int POOL_ENTRIES_DEF = 64;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int KEY_W = 31;
  localparam int KIND_W = 2;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 7;
  localparam int CFG_W = 3;
  localparam logic [31:0] HASH_MULT = 32'h9E3779B9;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd5;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_INS, S_FETCH, S_WAIT, S_CHECK,
    S_UNLINK, S_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic read_head;
    logic do_insert;
    logic read_entry;
    logic capture;
    logic do_unlink;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_insert;
    logic is_walk;
    logic pool_full;
    logic at_nil;
    logic match;
    logic is_search;
  } stat_t;

endpackage

// ===== rtl/chte_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module chte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/chte_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_ctrl
// Operation sequencer of the chained hash table engine.
// ----------------------------------------------------------------------------
module chte_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_free,
  input  chte_pkg::stat_t st,
  output logic            busy,
  output chte_pkg::cmd_t  cmd
);

  chte_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chte_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      chte_pkg::S_CLEAR: if (st.clear_last) state_next = chte_pkg::S_IDLE;
      chte_pkg::S_IDLE: if (in_fire) state_next = chte_pkg::S_HASH;
      chte_pkg::S_HASH: state_next = chte_pkg::S_HEAD;
      chte_pkg::S_HEAD: begin
        if (st.is_insert) state_next = chte_pkg::S_INS;
        else if (st.is_walk) state_next = chte_pkg::S_FETCH;
        else state_next = chte_pkg::S_DONE;
      end
      chte_pkg::S_INS: state_next = chte_pkg::S_DONE;
      chte_pkg::S_FETCH: begin
        if (st.at_nil) state_next = chte_pkg::S_DONE;
        else state_next = chte_pkg::S_WAIT;
      end
      chte_pkg::S_WAIT: state_next = chte_pkg::S_CHECK;
      chte_pkg::S_CHECK: begin
        if (st.match && st.is_search) state_next = chte_pkg::S_DONE;
        else if (st.match) state_next = chte_pkg::S_UNLINK;
        else state_next = chte_pkg::S_FETCH;
      end
      chte_pkg::S_UNLINK: state_next = chte_pkg::S_FETCH;
      chte_pkg::S_DONE: if (out_free) state_next = chte_pkg::S_IDLE;
      default: state_next = chte_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      chte_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      chte_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      chte_pkg::S_HASH: cmd = '0;
      chte_pkg::S_HEAD: cmd.read_head = 1'b1;
      chte_pkg::S_INS: cmd.do_insert = 1'b1;
      chte_pkg::S_FETCH: cmd.read_entry = 1'b1;
      chte_pkg::S_WAIT: cmd.capture = 1'b1;
      chte_pkg::S_CHECK: cmd.advance = !st.match;
      chte_pkg::S_UNLINK: cmd.do_unlink = 1'b1;
      chte_pkg::S_DONE: cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |-> $past(state) == chte_pkg::S_HEAD)
    else $error("insert outside head step");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_insert, cmd.do_unlink, cmd.clear_step}))
    else $error("conflicting memory writes");
  assert property (@(posedge clk) disable iff (rst)
    state == chte_pkg::S_UNLINK |=> state == chte_pkg::S_FETCH)
    else $error("unlink not followed by fetch");

endmodule

// ===== rtl/chte_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_datapath
// Hash, bucket heads, node pool and result register of the engine.
// ----------------------------------------------------------------------------
module chte_datapath #(
  parameter int BUCKETS = chte_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = chte_pkg::POOL_ENTRIES_DEF,
  parameter int HANDLE_BITS = chte_pkg::HANDLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  chte_pkg::cmd_t                  cmd,
  output chte_pkg::stat_t                 st,
  input  logic [chte_pkg::CFG_W-1:0]      cfg_log2,
  input  logic [chte_pkg::KIND_W-1:0]     in_kind,
  input  logic [chte_pkg::KEY_W-1:0]      in_key,
  input  logic [chte_pkg::HANDLE_W-1:0]   in_handle,
  input  logic                            out_take,
  output logic                            out_valid,
  output logic [chte_pkg::STATUS_W-1:0]   out_status,
  output logic [chte_pkg::HANDLE_W-1:0]   out_found,
  output logic [chte_pkg::COUNT_W-1:0]    out_removed
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam int MAXL = $clog2(BUCKETS + 1) - 1;
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
  localparam int HB = (HANDLE_BITS < chte_pkg::HANDLE_W) ? HANDLE_BITS : chte_pkg::HANDLE_W;

  logic [chte_pkg::KIND_W-1:0] kind;
  logic [chte_pkg::KEY_W-1:0] key;
  logic [HB-1:0] handle;
  logic [31:0] frac;
  logic [BW-1:0] bucket;
  logic [LW-1:0] cur, head_val, prev_r, next_r;
  logic [chte_pkg::KEY_W-1:0] key_r;
  logic [HB-1:0] hdl_r;
  logic [POOL_ENTRIES-1:0] free_map;
  logic [PW-1:0] free_idx;
  logic free_any;
  logic [BW-1:0] clr_cnt;
  logic [chte_pkg::COUNT_W-1:0] removed;
  logic [chte_pkg::STATUS_W-1:0] status;
  logic [chte_pkg::HANDLE_W-1:0] found;
  logic [LW-1:0] wr_next_data, wr_prev_data, head_wdata;
  logic [PW-1:0] wr_next_addr, wr_prev_addr;
  logic wr_next_en, wr_prev_en, head_we, node_we;
  logic [BW-1:0] head_waddr;
  logic [2:0] l_eff;
  logic [BW:0] b_raw;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_any = 1'b1;
        free_idx = PW'(i);
      end
    end
  end

  always_comb begin
    l_eff = (int'(cfg_log2) > MAXL) ? 3'(MAXL) : cfg_log2;
    b_raw = (l_eff == 3'd0) ? '0 : (BW + 1)'(frac >> (6'd32 - {3'd0, l_eff}));
    bucket = (b_raw >= (BW + 1)'(BUCKETS)) ? BW'(BUCKETS - 1) : b_raw[BW-1:0];
  end

  chte_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(bucket), .rdata(head_val));
  chte_ram #(.WIDTH(chte_pkg::KEY_W), .DEPTH(POOL_ENTRIES)) u_key (
    .clk(clk), .we(node_we), .waddr(free_idx), .wdata(key),
    .raddr(cur[PW-1:0]), .rdata(key_r));
  chte_ram #(.WIDTH(HB), .DEPTH(POOL_ENTRIES)) u_hdl (
    .clk(clk), .we(node_we), .waddr(free_idx), .wdata(handle),
    .raddr(cur[PW-1:0]), .rdata(hdl_r));
  chte_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_next (
    .clk(clk), .we(wr_next_en), .waddr(wr_next_addr), .wdata(wr_next_data),
    .raddr(cur[PW-1:0]), .rdata(next_r));
  chte_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_prev (
    .clk(clk), .we(wr_prev_en), .waddr(wr_prev_addr), .wdata(wr_prev_data),
    .raddr(cur[PW-1:0]), .rdata(prev_r));

  logic [LW-1:0] hv;
  logic head_loaded;

  // An insert links the old head back to the new node during the head step,
  // so that the insert step can mark the new node as the chain head.
  always_comb begin
    node_we = cmd.do_insert && free_any;
    head_we = cmd.clear_step || node_we ||
              (cmd.do_unlink && prev_r == NIL);
    head_waddr = cmd.clear_step ? clr_cnt : bucket;
    head_wdata = cmd.clear_step ? NIL : (node_we ? LW'(free_idx) : next_r);
    wr_next_en = node_we || (cmd.do_unlink && prev_r != NIL);
    wr_next_addr = node_we ? free_idx : prev_r[PW-1:0];
    wr_next_data = node_we ? hv : next_r;
    wr_prev_en = (cmd.read_head && kind == chte_pkg::KIND_INSERT && free_any &&
                  head_val != NIL) || node_we || (cmd.do_unlink && next_r != NIL);
    wr_prev_addr = cmd.read_head ? head_val[PW-1:0] :
                   (node_we ? free_idx : next_r[PW-1:0]);
    wr_prev_data = cmd.read_head ? LW'(free_idx) : (node_we ? NIL : prev_r);
  end

  assign hv = head_loaded ? cur : head_val;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_kind;
      key <= in_key;
      handle <= in_handle[HB-1:0];
      frac <= {1'b0, in_key} * chte_pkg::HASH_MULT;
      removed <= '0;
      status <= chte_pkg::ST_NOT_FOUND;
      found <= '0;
    end
    head_loaded <= cmd.read_head;
    if (cmd.read_head) cur <= head_val;
    if (cmd.do_insert) status <= free_any ? chte_pkg::ST_DONE : chte_pkg::ST_FULL;
    if (cmd.read_entry || cmd.capture) head_loaded <= 1'b0;
    if (cmd.advance || cmd.do_unlink) cur <= next_r;
    if (cmd.capture && key_r == key && kind == chte_pkg::KIND_SEARCH) begin
      status <= chte_pkg::ST_DONE;
      found <= chte_pkg::HANDLE_W'(hdl_r);
    end
    if (cmd.do_unlink) begin
      status <= chte_pkg::ST_DONE;
      if (removed != '1) removed <= removed + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
      clr_cnt <= '0;
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
      if (node_we) free_map[free_idx] <= 1'b0;
      if (cmd.do_unlink) free_map[cur[PW-1:0]] <= 1'b1;
    end
  end

  logic match_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) match_r <= (key_r == key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= status;
      out_found <= found;
      out_removed <= removed;
    end
  end

  always_comb begin
    st.clear_last = (clr_cnt == BW'(BUCKETS - 1)) || (BUCKETS == 1);
    st.is_insert = (kind == chte_pkg::KIND_INSERT);
    st.is_walk = (kind == chte_pkg::KIND_SEARCH) || (kind == chte_pkg::KIND_REMOVE);
    st.pool_full = !free_any;
    st.at_nil = (cur == NIL);
    st.match = match_r;
    st.is_search = (kind == chte_pkg::KIND_SEARCH);
  end

endmodule

// ===== rtl/chained_hash_table_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Hash table with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// One item is handled at a time. Insert passes the hash, head and insert states
// to the result register; an item of the unused kind skips the insert state.
// Search and remove pass the hash and head states, then the fetch, wait and
// check states per chain node visited (a search hit ends at check), plus an
// unlink state per node removed, set by the walk through the node RAMs with
// registered reads. The input is accepted again once the result is loaded, and
// a result that still waits for m_tready holds the next item in the done state.
// After reset a clearing pass writes each bucket head while no item is accepted.
module chained_hash_table_engine #(
  parameter int BUCKETS = chte_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = chte_pkg::POOL_ENTRIES_DEF,
  parameter int HANDLE_BITS = chte_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // kind
  input  logic [47:0] s_tdata,   // key[30:0], record_handle[46:31]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // status[1:0], found_handle[17:2], removed_count[24:18]
);

  logic [chte_pkg::CFG_W-1:0] cfg_log2;
  logic busy, in_fire;
  chte_pkg::cmd_t cmd;
  chte_pkg::stat_t st;
  logic [1:0] o_status;
  logic [15:0] o_found;
  logic [6:0] o_removed;

  always_ff @(posedge clk) begin
    if (rst) cfg_log2 <= chte_pkg::CFG_RESET;
    else if (cfg_we) cfg_log2 <= cfg_wdata;
  end

  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;

  chte_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_free(!m_tvalid || m_tready), .st(st), .busy(busy), .cmd(cmd));

  chte_datapath #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES),
                  .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .cfg_log2(cfg_log2),
    .in_kind(s_tuser), .in_key(s_tdata[30:0]), .in_handle(s_tdata[46:31]),
    .out_take(m_tready), .out_valid(m_tvalid), .out_status(o_status),
    .out_found(o_found), .out_removed(o_removed));

  assign m_tdata = {7'd0, o_removed, o_found, o_status};

endmodule
